// ===== hw/rtl/fdba_pkg.sv =====
// shared constants and types for the floppy drive byte port
`timescale 1ns / 1ps

package fdba_pkg;

   // disk image store
   localparam int unsigned IMAGE_BYTES = 1048576;
   localparam int unsigned ADDR_W      = $clog2(IMAGE_BYTES);

   // address arithmetic widths
   localparam int unsigned TRK_W = 10;  // linear track index
   localparam int unsigned SEC_W = 17;  // linear sector index
   localparam int unsigned ACC_W = 31;  // byte offset before range check

   // register indexes on the csr port
   localparam logic [2:0] REG_SIDE_COUNT   = 3'd0;
   localparam logic [2:0] REG_TRACK_COUNT  = 3'd1;
   localparam logic [2:0] REG_SECTORS      = 3'd2;
   localparam logic [2:0] REG_SECTOR_BYTES = 3'd3;
   localparam logic [2:0] REG_ACCESS_MODE  = 3'd4;
   localparam logic [2:0] REG_SIDE_MAJOR   = 3'd5;
   localparam logic [2:0] REG_DISK_PRESENT = 3'd6;
   localparam logic [2:0] REG_TRACK_LENGTH = 3'd7;

   // seek status codes
   localparam logic [1:0] SEEK_FOUND     = 2'd0;
   localparam logic [1:0] SEEK_NO_DISK   = 2'd1;
   localparam logic [1:0] SEEK_NO_SECTOR = 2'd2;

   localparam logic [7:0]  BYTE_NONE       = 8'hFF;
   localparam logic [12:0] RAW_SEEK_LENGTH = 13'd256;
   localparam logic [15:0] INDEX_LIMIT     = 16'd100;

   typedef enum logic [2:0] {
      CMD_SEEK          = 3'd0,
      CMD_READ_NEXT     = 3'd1,
      CMD_WRITE_NEXT    = 3'd2,
      CMD_WRITE_INPLACE = 3'd3,
      CMD_ADVANCE       = 3'd4,
      CMD_SET_POSITION  = 3'd5
   } cmd_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_TRK   = 7'b0000100,
      ST_SEC   = 7'b0001000,
      ST_ADR   = 7'b0010000,
      ST_MEM   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

// ===== hw/rtl/fdba_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module fdba_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/floppy_drive_byte_access.sv =====
// floppy drive byte port: head state, command sequencer and disk image store
//
// Requests arrive on the req_ channel (valid/stall); each carries one command:
// seek, read next, write next, write in place, advance or set position.
// Every accepted command produces exactly one result on the rsp_ channel,
// giving the byte read, the seek outcome, the fault flag, the index and
// track-zero lines and the head position after the command.
// Geometry and mode are set through the csr_ write port; the user must write
// them only while the block is idle, and the block itself does not enforce it.
// One command is in flight at a time: a new request is taken only once the
// last result is loaded. The path runs through the three-step address
// multiply chain (track, sector, byte), then the registered image ram read.
// A finished result waits in the output register while rsp_stall is high;
// the next request is already accepted behind it and holds in its final
// step until the output register frees.
// Reset is synchronous; afterwards the image ram is swept to zero, one byte
// per cycle, over all 1048576 bytes, during which req_stall stays high. csr
// writes are taken during the sweep.
`timescale 1ns / 1ps

module floppy_drive_byte_access (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_target_track,
   input  logic [7:0]  req_sector_number,
   input  logic        req_head_side_pin,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_new_position,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_seek_status,
   output logic [12:0] rsp_seek_length,
   output logic        rsp_access_fault,
   output logic        rsp_index_pulse,
   output logic        rsp_track_zero,
   output logic [15:0] rsp_position_now,
   // configuration
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int unsigned AW = fdba_pkg::ADDR_W;
   localparam int unsigned TW = fdba_pkg::TRK_W;
   localparam int unsigned SW = fdba_pkg::SEC_W;
   localparam int unsigned CW = fdba_pkg::ACC_W;

   // configuration registers
   logic [1:0]  side_count_ff;
   logic [7:0]  track_count_ff;
   logic [5:0]  sectors_ff;
   logic [12:0] sector_bytes_ff;
   logic        raw_mode_ff;
   logic        side_major_ff;
   logic        disk_present_ff;
   logic [15:0] track_length_ff;

   // head state
   logic [7:0]  track_ff, track_in;
   logic [7:0]  sector_ff, sector_in;
   logic        side_ff, side_in;
   logic [15:0] pos_ff, pos_in;

   // sequencer
   fdba_pkg::state_type state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   fdba_pkg::cmd_type cmd_ff;
   logic [7:0]        trk_req_ff;
   logic [7:0]        sec_req_ff;
   logic              pin_req_ff;
   logic [7:0]        data_req_ff;
   logic [15:0]       newpos_req_ff;
   logic [TW-1:0]     tidx_ff, tidx_in;
   logic [CW-1:0]     acc_ff, acc_in;
   logic              hit_ff, hit_in;
   logic              fault_ff, fault_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff;
   logic [1:0]  rsp_seek_status_ff;
   logic [12:0] rsp_seek_length_ff;
   logic        rsp_access_fault_ff;
   logic        rsp_index_pulse_ff;
   logic        rsp_track_zero_ff;
   logic [15:0] rsp_position_now_ff;

   // ram ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [7:0]    ram_rdata;

   logic req_xfer;
   logic out_free;
   logic cur_in_range;
   logic pos_in_sector;
   logic is_access;
   logic is_write;
   logic is_gap;
   logic acc_ok;
   logic clear_done;

   logic [15:0]   mul_spt;
   logic [25:0]   mul_tl;
   logic [29:0]   mul_sb;
   logic [SW-1:0] sec_lin;
   logic [16:0]   pos_inc;
   logic [15:0]   pos_wrap;

   logic [7:0]  res_read_data;
   logic [1:0]  res_seek_status;
   logic [12:0] res_seek_length;
   logic        seek_side;

   function automatic logic in_range_f(
      input logic       side,
      input logic [7:0] track,
      input logic [7:0] sector,
      input logic [1:0] side_count,
      input logic [7:0] track_count,
      input logic [5:0] sectors,
      input logic       raw_mode
   );
      logic ok;
      ok = ({1'b0, side} < side_count) && (track < track_count);
      if (!raw_mode) begin
         ok = ok && (sector <= {2'b00, sectors});
      end
      return ok;
   endfunction

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != fdba_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign clear_done = (clr_cnt_ff == AW'(fdba_pkg::IMAGE_BYTES - 1));

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         side_count_ff   <= 2'd1;
         track_count_ff  <= 8'd80;
         sectors_ff      <= 6'd16;
         sector_bytes_ff <= 13'd256;
         raw_mode_ff     <= 1'b0;
         side_major_ff   <= 1'b0;
         disk_present_ff <= 1'b0;
         track_length_ff <= 16'd6656;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fdba_pkg::REG_SIDE_COUNT:   side_count_ff   <= csr_write_data[1:0];
            fdba_pkg::REG_TRACK_COUNT:  track_count_ff  <= csr_write_data[7:0];
            fdba_pkg::REG_SECTORS:      sectors_ff      <= csr_write_data[5:0];
            fdba_pkg::REG_SECTOR_BYTES: sector_bytes_ff <= csr_write_data[12:0];
            fdba_pkg::REG_ACCESS_MODE:  raw_mode_ff     <= csr_write_data[0];
            fdba_pkg::REG_SIDE_MAJOR:   side_major_ff   <= csr_write_data[0];
            fdba_pkg::REG_DISK_PRESENT: disk_present_ff <= csr_write_data[0];
            fdba_pkg::REG_TRACK_LENGTH: track_length_ff <= csr_write_data;
         endcase
      end
   end

   // ---------------- address chain ----------------
   assign mul_spt = 16'(tidx_ff) * 16'(sectors_ff);
   assign mul_tl  = 26'(tidx_ff) * 26'(track_length_ff);
   assign mul_sb  = 30'(acc_ff[SW-1:0]) * 30'(sector_bytes_ff);
   assign sec_lin = SW'(mul_spt) + SW'(sector_ff) - SW'(1);

   assign cur_in_range = in_range_f(side_ff, track_ff, sector_ff, side_count_ff,
                                    track_count_ff, sectors_ff, raw_mode_ff);
   assign pos_in_sector = ({1'b0, pos_ff} < {4'b0000, sector_bytes_ff});
   assign is_gap   = !raw_mode_ff && cur_in_range && pos_in_sector && (sector_ff == 8'd0);
   assign is_write = (cmd_ff == fdba_pkg::CMD_WRITE_NEXT) ||
                     (cmd_ff == fdba_pkg::CMD_WRITE_INPLACE);
   assign is_access = disk_present_ff && !is_gap &&
                      ((cmd_ff == fdba_pkg::CMD_READ_NEXT) || is_write);
   assign acc_ok = cur_in_range && (raw_mode_ff || pos_in_sector) &&
                   (acc_ff < CW'(fdba_pkg::IMAGE_BYTES));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      tidx_in    = tidx_ff;
      acc_in     = acc_ff;
      hit_in     = hit_ff;
      fault_in   = fault_ff;
      unique case (state_ff)
         fdba_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clear_done) begin
               state_in = fdba_pkg::ST_IDLE;
            end
         end
         fdba_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = fdba_pkg::ST_TRK;
            end
         end
         fdba_pkg::ST_TRK: begin
            // whole-track mode always uses the cylinder-major order
            if (!raw_mode_ff && side_major_ff) begin
               tidx_in = (side_ff ? TW'(track_count_ff) : TW'(0)) + TW'(track_ff);
            end else begin
               tidx_in = TW'(track_ff) * TW'(side_count_ff) + TW'(side_ff);
            end
            state_in = fdba_pkg::ST_SEC;
         end
         fdba_pkg::ST_SEC: begin
            if (raw_mode_ff) begin
               acc_in = CW'(mul_tl) + CW'(pos_ff);
            end else begin
               acc_in = CW'(sec_lin);
            end
            state_in = fdba_pkg::ST_ADR;
         end
         fdba_pkg::ST_ADR: begin
            if (!raw_mode_ff) begin
               acc_in = CW'(mul_sb) + CW'(pos_ff);
            end
            state_in = fdba_pkg::ST_MEM;
         end
         fdba_pkg::ST_MEM: begin
            hit_in   = is_access && acc_ok;
            fault_in = is_access && !acc_ok;
            state_in = fdba_pkg::ST_DONE;
         end
         fdba_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fdba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdba_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fdba_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tidx_ff  <= tidx_in;
      acc_ff   <= acc_in;
      hit_ff   <= hit_in;
      fault_ff <= fault_in;
      if (req_xfer) begin
         cmd_ff        <= fdba_pkg::cmd_type'(req_command);
         trk_req_ff    <= req_target_track;
         sec_req_ff    <= req_sector_number;
         pin_req_ff    <= req_head_side_pin;
         data_req_ff   <= req_data_byte;
         newpos_req_ff <= req_new_position;
      end
   end

   // ---------------- image store ----------------
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = acc_ff[AW-1:0];
      ram_wdata = data_req_ff;
      ram_re    = 1'b0;
      if (state_ff == fdba_pkg::ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = 8'd0;
      end else if (state_ff == fdba_pkg::ST_MEM && is_access && acc_ok) begin
         ram_we = is_write;
         ram_re = !is_write;
      end
   end

   fdba_ram #(
      .DATA_W (8),
      .DEPTH  (fdba_pkg::IMAGE_BYTES)
   ) u_image (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (acc_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // ---------------- head update and result ----------------
   assign pos_inc  = {1'b0, pos_ff} + 17'd1;
   assign pos_wrap = (pos_inc >= {1'b0, track_length_ff}) ? 16'd0 : pos_inc[15:0];
   assign seek_side = (side_count_ff > 2'd1) ? !pin_req_ff : side_ff;

   always_comb begin
      track_in        = track_ff;
      sector_in       = sector_ff;
      side_in         = side_ff;
      pos_in          = pos_ff;
      res_read_data   = fdba_pkg::BYTE_NONE;
      res_seek_status = fdba_pkg::SEEK_FOUND;
      res_seek_length = 13'd0;
      unique case (cmd_ff)
         fdba_pkg::CMD_SEEK: begin
            if (!disk_present_ff) begin
               res_seek_status = fdba_pkg::SEEK_NO_DISK;
            end else begin
               side_in   = seek_side;
               track_in  = trk_req_ff;
               sector_in = sec_req_ff;
               pos_in    = 16'd0;
               if (!in_range_f(seek_side, trk_req_ff, sec_req_ff, side_count_ff,
                               track_count_ff, sectors_ff, raw_mode_ff)) begin
                  res_seek_status = fdba_pkg::SEEK_NO_SECTOR;
               end else begin
                  res_seek_length = raw_mode_ff ? fdba_pkg::RAW_SEEK_LENGTH
                                                : sector_bytes_ff;
               end
            end
         end
         fdba_pkg::CMD_READ_NEXT, fdba_pkg::CMD_WRITE_NEXT: begin
            if (hit_ff) begin
               pos_in = raw_mode_ff ? pos_wrap : pos_inc[15:0];
               if (cmd_ff == fdba_pkg::CMD_READ_NEXT) begin
                  res_read_data = ram_rdata;
               end
            end
         end
         fdba_pkg::CMD_WRITE_INPLACE: begin
            pos_in = pos_ff;
         end
         fdba_pkg::CMD_ADVANCE: begin
            pos_in = cur_in_range ? pos_wrap : 16'd0;
         end
         fdba_pkg::CMD_SET_POSITION: begin
            pos_in = newpos_req_ff;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == fdba_pkg::ST_DONE) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= 8'd0;
         sector_ff    <= 8'd0;
         side_ff      <= 1'b0;
         pos_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == fdba_pkg::ST_DONE && out_free) begin
            track_ff  <= track_in;
            sector_ff <= sector_in;
            side_ff   <= side_in;
            pos_ff    <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == fdba_pkg::ST_DONE && out_free) begin
         rsp_read_data_ff    <= res_read_data;
         rsp_seek_status_ff  <= res_seek_status;
         rsp_seek_length_ff  <= res_seek_length;
         rsp_access_fault_ff <= fault_ff;
         rsp_index_pulse_ff  <= (pos_in < fdba_pkg::INDEX_LIMIT) &&
                                (raw_mode_ff || (sector_in == 8'd0));
         rsp_track_zero_ff   <= (track_in == 8'd0);
         rsp_position_now_ff <= pos_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_seek_status  = rsp_seek_status_ff;
   assign rsp_seek_length  = rsp_seek_length_ff;
   assign rsp_access_fault = rsp_access_fault_ff;
   assign rsp_index_pulse  = rsp_index_pulse_ff;
   assign rsp_track_zero   = rsp_track_zero_ff;
   assign rsp_position_now = rsp_position_now_ff;

`ifndef SYNTH
   // outside the sweep the image is written only from the memory step of a write
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != fdba_pkg::ST_CLEAR) |->
      (state_ff == fdba_pkg::ST_MEM && is_write))
      else $error("image write outside a write command");

   // a faulted access never returns data
   a_fault_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_access_fault) |-> (rsp_read_data == fdba_pkg::BYTE_NONE))
      else $error("fault with read data");

   // a finished command always lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdba_pkg::ST_DONE && out_free) |=> rsp_valid)
      else $error("result lost");

   // no read and write of the image in the same cycle
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("image read and write together");
`endif

endmodule
